>>> rtl/mrfc_pkg.sv
// Shared types, constants and the CRC-16 byte update for the Modbus RTU frame checker.
package mrfc_pkg;

    localparam int MAX_FRAME = 256;
    localparam int MIN_FRAME = 4;
    localparam int CNT_W     = $clog2(MAX_FRAME + 2);
    localparam int PLEN_W    = 9;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam int          EXC_BIT  = 7;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_SHORT = 3'd1,
        ST_CRC   = 3'd2,
        ST_EXC   = 3'd3,
        ST_LONG  = 3'd4
    } t_status;

    typedef struct packed {
        logic              payload_valid;
        logic [7:0]        payload_byte;
        logic              frame_done;
        t_status           status;
        logic [7:0]        exception_code;
        logic [PLEN_W-1:0] payload_length;
    } t_result;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> rtl/mrfc_frame_core.sv
// Frame state, running CRC and verdict logic for one byte per transaction.
module mrfc_frame_core
    import mrfc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_end_of_frame,
    output logic       o_has_result,
    output t_result    o_result
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_FRAME);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_TWO = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_FIVE = CNT_W'(5);

    logic [CNT_W-1:0] r_count, n_count;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_older, n_older;
    logic [7:0]       r_newer, n_newer;
    logic [7:0]       r_func, n_func;
    logic [7:0]       r_exc, n_exc;
    logic             r_ovf, n_ovf;

    logic [CNT_W-1:0] total;
    logic             emit;
    logic [15:0]      crc_upd;
    logic [15:0]      rx_crc;
    logic [CNT_W-1:0] plen;

    always_comb begin
        emit    = (r_count >= CNT_TWO);
        crc_upd = emit ? crc_fold(r_crc, r_older) : r_crc;
        n_ovf   = r_ovf || (r_count >= CNT_MAX);
        total   = (r_count >= CNT_MAX) ? CNT_SAT : r_count + CNT_ONE;
        rx_crc  = {i_rx_byte, r_newer};
        plen    = (total >= CNT_TWO) ? total - CNT_TWO : '0;

        o_result                = '0;
        o_result.payload_valid  = emit;
        o_result.payload_byte   = emit ? r_older : 8'h00;
        o_result.frame_done     = i_end_of_frame;
        o_result.status         = ST_OK;
        o_result.exception_code = 8'h00;
        o_result.payload_length = '0;
        if (i_end_of_frame) begin
            o_result.payload_length = PLEN_W'(plen);
            priority if (n_ovf) begin
                o_result.status = ST_LONG;
            end else if (total < CNT_MIN) begin
                o_result.status = ST_SHORT;
            end else if (crc_upd != rx_crc) begin
                o_result.status = ST_CRC;
            end else if (r_func[EXC_BIT]) begin
                o_result.status         = ST_EXC;
                o_result.exception_code = (total >= CNT_FIVE) ? r_exc : 8'h00;
            end else begin
                o_result.status = ST_OK;
            end
        end
        o_has_result = emit || i_end_of_frame;

        if (i_end_of_frame) begin
            n_count = '0;
            n_crc   = CRC_INIT;
            n_older = 8'h00;
            n_newer = 8'h00;
            n_func  = 8'h00;
            n_exc   = 8'h00;
        end else begin
            n_count = total;
            n_crc   = crc_upd;
            n_older = r_newer;
            n_newer = i_rx_byte;
            n_func  = (r_count == CNT_ONE) ? i_rx_byte : r_func;
            n_exc   = (r_count == CNT_TWO) ? i_rx_byte : r_exc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= CRC_INIT;
            r_older <= 8'h00;
            r_newer <= 8'h00;
            r_func  <= 8'h00;
            r_exc   <= 8'h00;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            r_count <= n_count;
            r_crc   <= n_crc;
            r_older <= n_older;
            r_newer <= n_newer;
            r_func  <= n_func;
            r_exc   <= n_exc;
            r_ovf   <= i_end_of_frame ? 1'b0 : n_ovf;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_SAT)
        else $error("byte count beyond saturation");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_end_of_frame |=> r_count == '0 && r_crc == CRC_INIT && !r_ovf)
        else $error("frame state not cleared after last byte");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> r_count == CNT_SAT)
        else $error("overflow flag without saturated count");

endmodule

>>> rtl/mrfc_out_stage.sv
// Result register that decouples the input side from a stalled output.
module mrfc_out_stage
    import mrfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_accept,
    input  logic    i_has_result,
    input  t_result i_result,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    logic    r_valid, n_valid;
    t_result r_res;

    assign o_in_ready  = !r_valid || i_out_ready;
    assign o_accept    = i_in_valid && o_in_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_res;

    always_comb begin
        n_valid = r_valid;
        if (o_accept) begin
            n_valid = i_has_result;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_accept && i_has_result) begin
            r_res <= i_result;
        end
    end

    a_result_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_res.payload_valid || r_res.frame_done))
        else $error("empty result presented");

    a_status_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_res.frame_done |-> r_res.status == ST_OK && r_res.payload_length == '0)
        else $error("verdict fields set without frame end");

endmodule

>>> rtl/modbus_rtu_frame_checker_top.sv
// Top level of the Modbus RTU response frame checker.
//
//  Channel | Handshake                  | Payload
//  input   | i_in_valid / o_in_ready    | i_rx_byte, i_end_of_frame
//  output  | o_out_valid / i_out_ready  | o_payload_valid, o_payload_byte, o_frame_done,
//          |                            | o_status, o_exception_code, o_payload_length
//
// One byte is accepted per cycle while o_in_ready is high; its result is registered.
// The CRC update and the verdict are computed in the same cycle the byte is accepted.
// Synchronous active-low reset clears frame state and empties the result register.
// A byte is accepted while the result register is empty or being drained in that cycle.
// Bytes with no result (the first two of a frame) do not load the result register.
module modbus_rtu_frame_checker_top
    import mrfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_rx_byte,
    input  logic              i_end_of_frame,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_payload_valid,
    output logic [7:0]        o_payload_byte,
    output logic              o_frame_done,
    output logic [2:0]        o_status,
    output logic [7:0]        o_exception_code,
    output logic [PLEN_W-1:0] o_payload_length
);

    logic    accept;
    logic    has_result;
    t_result core_result;
    t_result out_result;

    mrfc_frame_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_rx_byte      (i_rx_byte),
        .i_end_of_frame (i_end_of_frame),
        .o_has_result   (has_result),
        .o_result       (core_result)
    );

    mrfc_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .o_accept     (accept),
        .i_has_result (has_result),
        .i_result     (core_result),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_result     (out_result)
    );

    assign o_payload_valid  = out_result.payload_valid;
    assign o_payload_byte   = out_result.payload_byte;
    assign o_frame_done     = out_result.frame_done;
    assign o_status         = out_result.status;
    assign o_exception_code = out_result.exception_code;
    assign o_payload_length = out_result.payload_length;

endmodule
